// ===== hw/rtl/rsff_pkg.sv =====
// Shared constants, types and command/status structs for the report segmenter frame FIFO.
package rsff_pkg;

  // Ring geometry.
  localparam int FRAME_SLOTS = 256;
  localparam int FRAME_BYTES = 64;
  localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int BYTE_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
  localparam int STORE_DEPTH = FRAME_SLOTS * FRAME_BYTES;
  localparam int STORE_AW    = SLOT_W + BYTE_W;

  // Message assembly limits.
  localparam int MSG_MAX     = 186;
  localparam int HELD_W      = 9;

  // Frame type codes.
  localparam logic [7:0] TYPE_SINGLE = 8'h00;
  localparam logic [7:0] TYPE_FIRST  = 8'h01;
  localparam logic [7:0] TYPE_MIDDLE = 8'h02;
  localparam logic [7:0] TYPE_FINAL  = 8'h03;

  // Segmentation thresholds and payload offsets.
  localparam logic [7:0] LEN_ONE_LIMIT   = 8'd63;
  localparam logic [7:0] LEN_THREE_LIMIT = 8'd125;
  localparam logic [7:0] PAYLOAD_MAX     = 8'd62;
  localparam logic [7:0] OFF_SECOND      = 8'd62;
  localparam logic [7:0] OFF_THIRD       = 8'd124;
  localparam logic [7:0] MSG_LIMIT       = 8'd186;

  // Value carried by a message queued notification.
  localparam logic [7:0] NOTIFY_BYTE = 8'hF0;

  // Input item modes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_BUILD,
    ST_NOTIFY,
    ST_POP
  } rsff_state_t;

  typedef struct packed {
    logic store_byte;
    logic pop_start;
    logic frame_begin;
    logic build_step;
    logic frame_next;
    logic notify_issue;
    logic pop_issue;
  } rsff_cmd_t;

  typedef struct packed {
    logic ring_full;
    logic last_frame;
    logic byte_end;
    logic issue_ok;
  } rsff_status_t;

endpackage

// ===== hw/rtl/report_segmenter_frame_fifo_unit.sv =====
// Top level of the report segmenter frame FIFO: controller and datapath.
//
// Input channel (in_valid/in_stall): each transfer carries mode, msg_byte and
// last_byte. A byte transfer (mode 0) is stored in the assembly buffer. The
// transfer with last_byte set closes the message: it is cut into one to three
// 64-byte frames, each written into the ring as a setup step followed by 64 byte
// writes through the single frame store write port; a frame that finds the
// ring full is dropped and counted, and then one notification result is
// produced. A pop transfer (mode 1) streams 64 result bytes, one per cycle while
// the output is not stalled, from the frame store read port (zeros when the ring
// was empty), and the block takes its next input only after the last of those
// bytes is issued.
// Output channel (out_valid/out_stall): one result per transfer. A staging
// register and an output register sit in front of the port, so results keep
// flowing at one per cycle while the receiver takes them; while out_stall is
// high the output holds and the block pauses its reads.
// Reset (rst, synchronous) empties the ring and the assembly buffer counters;
// no clearing pass runs, and the block accepts input as soon as reset is
// released.
module report_segmenter_frame_fifo_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [7:0]                  msg_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic                        pop_was_empty,
  output logic [1:0]                  frames_dropped,
  output logic                        truncated,
  output logic [rsff_pkg::HELD_W-1:0] frames_held
);
  import rsff_pkg::*;

  rsff_cmd_t    cmd;
  rsff_status_t status;

  // Sequencing of the work.
  rsff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .last_byte (last_byte),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // Storage, pointers and result path.
  rsff_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .msg_byte       (msg_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .pop_was_empty  (pop_was_empty),
    .frames_dropped (frames_dropped),
    .truncated      (truncated),
    .frames_held    (frames_held)
  );

endmodule

// ===== hw/rtl/rsff_ctrl.sv =====
// Controller state machine that sequences byte intake, frame building, notices and pops.
module rsff_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  mode,
  input  logic                  last_byte,
  input  rsff_pkg::rsff_status_t status,
  output logic                  in_stall,
  output rsff_pkg::rsff_cmd_t    cmd
);
  import rsff_pkg::*;

  rsff_state_t state;
  rsff_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_POP) begin
            state_next = ST_POP;
          end else if (last_byte) begin
            state_next = ST_FRAME;
          end
        end
      end
      ST_FRAME: begin
        if (status.ring_full) begin
          state_next = status.last_frame ? ST_NOTIFY : ST_FRAME;
        end else begin
          state_next = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (status.byte_end) begin
          state_next = status.last_frame ? ST_NOTIFY : ST_FRAME;
        end
      end
      ST_NOTIFY: begin
        if (status.issue_ok) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        if (status.issue_ok && status.byte_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath and the input handshake.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.store_byte = in_valid && (mode == MODE_BYTE);
        cmd.pop_start  = in_valid && (mode == MODE_POP);
      end
      ST_FRAME: begin
        cmd.frame_begin = 1'b1;
        cmd.frame_next  = status.ring_full;
      end
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        cmd.frame_next = status.byte_end;
      end
      ST_NOTIFY: begin
        cmd.notify_issue = status.issue_ok;
      end
      ST_POP: begin
        cmd.pop_issue = status.issue_ok;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rsff_datapath.sv =====
// Datapath: assembly buffer, frame store ring, pointers, build pipeline and result registers.
module rsff_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rsff_pkg::rsff_cmd_t           cmd,
  output rsff_pkg::rsff_status_t        status,
  input  logic [7:0]                   msg_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         pop_was_empty,
  output logic [1:0]                   frames_dropped,
  output logic                         truncated,
  output logic [rsff_pkg::HELD_W-1:0]  frames_held
);
  import rsff_pkg::*;

  // Memories.
  logic [7:0] asm_mem [MSG_MAX];
  logic [7:0] store_mem [STORE_DEPTH];

  // Control registers.
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [CNT_W-1:0]  held_count;
  logic [7:0]        bytes_received;
  logic              overflowed;
  logic [1:0]        dropped;
  logic [1:0]        frame_idx;
  logic [BYTE_W-1:0] byte_idx;
  logic              pop_empty;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] rd_base;

  // Build pipeline registers.
  logic                wr_valid;
  logic [STORE_AW-1:0] wr_addr;
  logic                wr_use_asm;
  logic [7:0]          wr_const;
  logic [7:0]          asm_rdata;

  // Result staging registers.
  logic              stage_valid;
  logic              stage_from_mem;
  logic              stage_kind;
  logic [7:0]        stage_byte;
  logic              stage_last;
  logic              stage_empty;
  logic [1:0]        stage_dropped;
  logic              stage_trunc;
  logic [CNT_W-1:0]  stage_held;
  logic [7:0]        store_rdata;

  // Combinational helpers.
  logic              ring_full;
  logic              ring_empty;
  logic [1:0]        num_frames;
  logic              single;
  logic [7:0]        frame_type;
  logic [7:0]        frame_off;
  logic [7:0]        frame_n;
  logic [BYTE_W-1:0] pay_i;
  logic              is_payload;
  logic [7:0]        asm_raddr;
  logic              issue;
  logic              move;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // Ring status and segmentation of the assembled message.
  always_comb begin
    ring_full  = (held_count == CNT_W'(FRAME_SLOTS));
    ring_empty = (held_count == '0);
    if (bytes_received < LEN_ONE_LIMIT) begin
      num_frames = 2'd1;
    end else if (bytes_received < LEN_THREE_LIMIT) begin
      num_frames = 2'd2;
    end else begin
      num_frames = 2'd3;
    end
    single     = (num_frames == 2'd1);
    frame_type = single ? TYPE_SINGLE : (TYPE_FIRST + {6'd0, frame_idx});
    case (frame_idx)
      2'd0:    frame_off = '0;
      2'd1:    frame_off = OFF_SECOND;
      default: frame_off = OFF_THIRD;
    endcase
    if (single) begin
      frame_n = bytes_received;
    end else if (frame_type == TYPE_FIRST) begin
      frame_n = PAYLOAD_MAX;
    end else if (frame_type == TYPE_MIDDLE) begin
      frame_n = (num_frames == 2'd2) ? (bytes_received - OFF_SECOND) : PAYLOAD_MAX;
    end else begin
      frame_n = bytes_received - OFF_THIRD;
    end
    pay_i      = byte_idx - BYTE_W'(2);
    is_payload = (byte_idx >= BYTE_W'(2)) && ({{(8 - BYTE_W){1'b0}}, pay_i} < frame_n);
    asm_raddr  = is_payload ? (frame_off + {{(8 - BYTE_W){1'b0}}, pay_i}) : '0;
  end

  // Result hand-off between staging and output registers.
  assign issue = cmd.pop_issue || cmd.notify_issue;
  assign move  = stage_valid && (!out_valid || !out_stall);

  always_comb begin
    status.ring_full  = ring_full;
    status.last_frame = (frame_idx == (num_frames - 2'd1));
    status.byte_end   = (byte_idx == BYTE_W'(FRAME_BYTES - 1));
    status.issue_ok   = !stage_valid || move;
  end

  // Message intake into the assembly buffer.
  always_ff @(posedge clk) begin
    if (cmd.store_byte && (bytes_received < MSG_LIMIT)) begin
      asm_mem[bytes_received] <= msg_byte;
    end
  end

  // Registered read of the assembly buffer for frame building.
  always_ff @(posedge clk) begin
    if (cmd.build_step) begin
      asm_rdata <= asm_mem[asm_raddr];
    end
  end

  // Frame store write port, written in the cycle after the build step.
  always_ff @(posedge clk) begin
    if (wr_valid) begin
      store_mem[wr_addr] <= wr_use_asm ? asm_rdata : wr_const;
    end
  end

  // Frame store registered read port for pops.
  always_ff @(posedge clk) begin
    if (cmd.pop_issue && !pop_empty) begin
      store_rdata <= store_mem[{rd_base, byte_idx}];
    end
  end

  // Build pipeline payload.
  always_ff @(posedge clk) begin
    if (cmd.build_step) begin
      wr_addr    <= {cur_slot, byte_idx};
      wr_use_asm <= is_payload;
      if (byte_idx == '0) begin
        wr_const <= frame_type;
      end else if (byte_idx == BYTE_W'(1)) begin
        wr_const <= bytes_received;
      end else begin
        wr_const <= '0;
      end
    end
  end

  // Control registers: pointers, counts and message state.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= '0;
      read_slot      <= '0;
      held_count     <= '0;
      bytes_received <= '0;
      overflowed     <= 1'b0;
      dropped        <= '0;
      frame_idx      <= '0;
      byte_idx       <= '0;
      pop_empty      <= 1'b0;
      wr_valid       <= 1'b0;
      stage_valid    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      wr_valid    <= cmd.build_step;
      stage_valid <= issue || (stage_valid && !move);
      out_valid   <= move || (out_valid && out_stall);
      if (cmd.store_byte) begin
        if (bytes_received < MSG_LIMIT) begin
          bytes_received <= bytes_received + 8'd1;
        end else begin
          overflowed <= 1'b1;
        end
      end
      if (cmd.pop_start) begin
        pop_empty <= ring_empty;
        if (!ring_empty) begin
          read_slot  <= next_slot(read_slot);
          held_count <= held_count - CNT_W'(1);
        end
      end
      if (cmd.frame_begin) begin
        if (ring_full) begin
          dropped <= dropped + 2'd1;
        end else begin
          write_slot <= next_slot(write_slot);
          held_count <= held_count + CNT_W'(1);
        end
      end
      if (cmd.frame_next) begin
        frame_idx <= frame_idx + 2'd1;
      end
      if (cmd.build_step || cmd.pop_issue) begin
        byte_idx <= byte_idx + BYTE_W'(1);
      end
      if (cmd.notify_issue) begin
        bytes_received <= '0;
        overflowed     <= 1'b0;
        dropped        <= '0;
        frame_idx      <= '0;
      end
    end
  end

  // Slot latches for the frame under construction and the frame being popped.
  always_ff @(posedge clk) begin
    if (cmd.frame_begin) begin
      cur_slot <= write_slot;
    end
    if (cmd.pop_start) begin
      rd_base <= read_slot;
    end
  end

  // Result staging register.
  always_ff @(posedge clk) begin
    if (issue) begin
      stage_from_mem <= cmd.pop_issue && !pop_empty;
      stage_kind     <= cmd.notify_issue;
      stage_byte     <= cmd.notify_issue ? NOTIFY_BYTE : '0;
      stage_last     <= cmd.notify_issue || status.byte_end;
      stage_empty    <= cmd.pop_issue && pop_empty;
      stage_dropped  <= cmd.notify_issue ? dropped : 2'd0;
      stage_trunc    <= cmd.notify_issue && overflowed;
      stage_held     <= held_count;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (move) begin
      out_kind       <= stage_kind;
      out_byte       <= stage_from_mem ? store_rdata : stage_byte;
      out_last       <= stage_last;
      pop_was_empty  <= stage_empty;
      frames_dropped <= stage_dropped;
      truncated      <= stage_trunc;
      frames_held    <= HELD_W'(stage_held);
    end
  end

endmodule

// ===== hw/rtl/rsff_checker.sv =====
// Port-level checker for the report segmenter frame FIFO and its bind statement.
module rsff_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_kind,
  input logic [7:0]                  out_byte,
  input logic                        out_last,
  input logic                        pop_was_empty,
  input logic [1:0]                  frames_dropped,
  input logic                        truncated
);
  import rsff_pkg::*;

  // A notification always carries the notice value and closes its transfer group.
  a_notice_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind) |-> (out_byte == NOTIFY_BYTE) && out_last)
    else $error("notification result has wrong byte or last flag");

  // An empty pop gives only zero frame bytes with no notice fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pop_was_empty) |->
      (out_byte == 8'h00) && !out_kind && (frames_dropped == 2'd0) && !truncated)
    else $error("empty pop result is not zero");

  // After reset the block is ready for input and holds no result.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind report_segmenter_frame_fifo_unit rsff_checker u_rsff_checker (.*);

// ===== tb/rsff_frame_checker.sv =====
// Checker for the report segmenter frame FIFO: predicts every result and compares it.
module rsff_frame_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        mode,
  input  logic [7:0]                  msg_byte,
  input  logic                        last_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_kind,
  input  logic [7:0]                  out_byte,
  input  logic                        out_last,
  input  logic                        pop_was_empty,
  input  logic [1:0]                  frames_dropped,
  input  logic                        truncated,
  input  logic [rsff_pkg::HELD_W-1:0] frames_held,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rsff_pkg::*;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;
  localparam int   SHOWN_MAX   = 10;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic              last;
    logic              empty;
    logic [1:0]        dropped;
    logic              cut;
    logic [HELD_W-1:0] held;
  } seg_result_t;

  // Shadow copy of the ring and of the message being assembled.
  logic [7:0]        ring_store [FRAME_SLOTS][FRAME_BYTES];
  logic [SLOT_W-1:0] head_slot;
  logic [SLOT_W-1:0] tail_slot;
  logic [HELD_W-1:0] frame_count;
  logic [7:0]        msg_buf [MSG_MAX];
  logic [7:0]        msg_len;
  logic              msg_cut;

  seg_result_t       expected_q [$];
  int                mismatches = 0;

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // Builds one frame from the assembly buffer; returns 1 when the ring is full.
  function automatic logic store_frame(input logic [7:0] ftype, input int off, input int n);
    if (frame_count >= HELD_W'(FRAME_SLOTS)) return 1'b1;
    for (int i = 0; i < FRAME_BYTES; i++) ring_store[head_slot][i] = 8'h00;
    ring_store[head_slot][0] = ftype;
    ring_store[head_slot][1] = msg_len;
    for (int i = 0; i < n && i < int'(PAYLOAD_MAX); i++)
      ring_store[head_slot][2 + i] = msg_buf[off + i];
    head_slot   = slot_after(head_slot);
    frame_count = frame_count + HELD_W'(1);
    return 1'b0;
  endfunction

  // Works out the results caused by one accepted input transfer.
  task automatic predict_item(input logic m, input logic [7:0] b, input logic l);
    seg_result_t       r;
    logic [1:0]        lost;
    logic [SLOT_W-1:0] slot;
    logic              was_empty;
    if (m == MODE_POP) begin
      was_empty = (frame_count == '0);
      slot      = tail_slot;
      if (!was_empty) begin
        tail_slot   = slot_after(tail_slot);
        frame_count = frame_count - HELD_W'(1);
      end
      for (int k = 0; k < FRAME_BYTES; k++) begin
        r       = '0;
        r.kind  = KIND_FRAME;
        r.data  = was_empty ? 8'h00 : ring_store[slot][k];
        r.last  = (k == FRAME_BYTES - 1);
        r.empty = was_empty;
        r.held  = frame_count;
        expected_q.push_back(r);
      end
    end else begin
      // Bytes past the limit are not kept, but the message is marked as cut.
      if (msg_len < MSG_LIMIT) begin
        msg_buf[msg_len] = b;
        msg_len          = msg_len + 8'd1;
      end else begin
        msg_cut = 1'b1;
      end
      if (l) begin
        lost = 2'd0;
        if (msg_len < LEN_ONE_LIMIT) begin
          lost += 2'(store_frame(TYPE_SINGLE, 0, int'(msg_len)));
        end else if (msg_len < LEN_THREE_LIMIT) begin
          lost += 2'(store_frame(TYPE_FIRST, 0, int'(PAYLOAD_MAX)));
          lost += 2'(store_frame(TYPE_MIDDLE, int'(OFF_SECOND),
                                 int'(msg_len) - int'(OFF_SECOND)));
        end else begin
          lost += 2'(store_frame(TYPE_FIRST, 0, int'(PAYLOAD_MAX)));
          lost += 2'(store_frame(TYPE_MIDDLE, int'(OFF_SECOND), int'(PAYLOAD_MAX)));
          lost += 2'(store_frame(TYPE_FINAL, int'(OFF_THIRD),
                                 int'(msg_len) - int'(OFF_THIRD)));
        end
        r         = '0;
        r.kind    = KIND_NOTICE;
        r.data    = NOTIFY_BYTE;
        r.last    = 1'b1;
        r.dropped = lost;
        r.cut     = msg_cut;
        r.held    = frame_count;
        expected_q.push_back(r);
        msg_len = '0;
        msg_cut = 1'b0;
      end
    end
  endtask

  function automatic string show_result(input seg_result_t r);
    return $sformatf("kind=%0d byte=%02h last=%0d empty=%0d dropped=%0d cut=%0d held=%0d",
                     r.kind, r.data, r.last, r.empty, r.dropped, r.cut, r.held);
  endfunction

  // Compares one accepted result with the oldest expectation.
  task automatic check_result(input seg_result_t got);
    seg_result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("%0t: unexpected result %s", $realtime, show_result(got));
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show_result(want));
          $display("  actual   %s", show_result(got));
        end
      end
    end
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      head_slot   = '0;
      tail_slot   = '0;
      frame_count = '0;
      msg_len     = '0;
      msg_cut     = 1'b0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_item(mode, msg_byte, last_byte);
      if (out_valid && !out_stall)
        check_result({out_kind, out_byte, out_last, pop_was_empty, frames_dropped,
                      truncated, frames_held});
    end
    pending    = expected_q.size();
    fail_count = mismatches + expected_q.size();
  end

endmodule

// ===== tb/tb_report_segmenter_frame_fifo_unit.sv =====
// Testbench top for the report segmenter frame FIFO: stimulus, receiver and verdict.
module tb_report_segmenter_frame_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rsff_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int HOLD_CYCLES   = 400;
  localparam int MIXED_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 200;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              mode           = MODE_BYTE;
  logic [7:0]        msg_byte       = 8'h00;
  logic              last_byte      = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_kind;
  logic [7:0]        out_byte;
  logic              out_last;
  logic              pop_was_empty;
  logic [1:0]        frames_dropped;
  logic              truncated;
  logic [HELD_W-1:0] frames_held;

  int fail_count;
  int pending;

  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  int sent_items = 0;
  int held_guess = 0;

  // Lengths around the one, two and three frame boundaries and the cut limit.
  int boundary_lens [14] = '{1, 2, 61, 62, 63, 64, 123, 124, 125, 126, 185, 186, 187, 200};

  report_segmenter_frame_fifo_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .msg_byte       (msg_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .pop_was_empty  (pop_was_empty),
    .frames_dropped (frames_dropped),
    .truncated      (truncated),
    .frames_held    (frames_held)
  );

  rsff_frame_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .msg_byte       (msg_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .pop_was_empty  (pop_was_empty),
    .frames_dropped (frames_dropped),
    .truncated      (truncated),
    .frames_held    (frames_held),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Offers one input transfer and returns at the falling edge after it is taken.
  task automatic send_item(input logic m, input logic [7:0] b, input logic l);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    msg_byte  <= b;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Sends a whole message of random bytes and tracks how full the ring gets.
  task automatic send_message(input int len);
    int kept;
    int frames;
    for (int i = 0; i < len; i++)
      send_item(MODE_BYTE, 8'($urandom_range(0, 255)), i == len - 1);
    kept   = (len > MSG_MAX) ? MSG_MAX : len;
    frames = (kept < int'(LEN_ONE_LIMIT)) ? 1 : (kept < int'(LEN_THREE_LIMIT)) ? 2 : 3;
    held_guess = (held_guess + frames > FRAME_SLOTS) ? FRAME_SLOTS : held_guess + frames;
  endtask

  // A pop ignores the byte fields, so they carry noise.
  task automatic send_pop();
    send_item(MODE_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (held_guess > 0) held_guess--;
  endtask

  function automatic int pick_length();
    int c;
    c = $urandom_range(0, 99);
    if (c < 40) return $urandom_range(1, 62);
    if (c < 65) return boundary_lens[$urandom_range(0, 13)];
    if (c < 85) return $urandom_range(63, 124);
    return $urandom_range(125, 200);
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    bit pressed;
    pressed = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pops with noisy fields, byte extremes, short messages.
    send_item(MODE_POP, 8'hFF, 1'b1);
    send_item(MODE_POP, 8'h00, 1'b0);
    send_item(MODE_BYTE, 8'h00, 1'b0);
    send_item(MODE_BYTE, 8'hFF, 1'b1);
    send_item(MODE_BYTE, 8'hFF, 1'b1);
    send_item(MODE_BYTE, 8'h00, 1'b1);
    repeat (4) send_pop();

    // Mixed messages and pops, with one long receiver hold-off halfway.
    while (sent_items < MIXED_ITEMS) begin
      if (!pressed && sent_items > MIXED_ITEMS / 2) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        repeat (12) send_pop();
        send_message(5);
      end else if ($urandom_range(0, 99) < 55) begin
        send_message(pick_length());
      end else begin
        repeat ($urandom_range(1, 3)) send_pop();
      end
    end

    // Fill the ring, then push messages that lose one, two and three frames.
    while (held_guess < FRAME_SLOTS) send_message(1);
    send_message(1);
    send_message(63);
    send_message(125);

    // Pop a few frames from the full ring without idling.
    calm = 1'b1;
    repeat (6) send_pop();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule
